@@ design/cbt_pkg.sv @@
// Shared constants, codes and types for the callback timer bank.
package cbt_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int FUNC_W = 3;
  localparam int SLOT_W = 4;
  localparam int TICK_W = 32;
  localparam int TAG_W  = 32;

  localparam logic [FUNC_W-1:0] FUNC_START   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_STOP    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_POLL    = 3'd4;

  // Control write broadcast to every cell; each cell qualifies with its own select.
  typedef struct packed {
    logic              start;
    logic              stop;
    logic              restart;
    logic              update;
    logic [TICK_W-1:0] now;
    logic [TICK_W-1:0] timeout;
    logic [TAG_W-1:0]  tag;
  } cell_wr_t;

  // Poll outcome of one cell; tag is zero when there is no hit.
  typedef struct packed {
    logic             hit;
    logic [TAG_W-1:0] tag;
  } cell_hit_t;

endpackage

@@ design/cbt_if.sv @@
// Handshake interfaces for the command and event channels.
interface cbt_cmd_if import cbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SLOT_W-1:0] slot;
  logic [TICK_W-1:0] timeout_ticks;
  logic [TAG_W-1:0]  user_tag;
  logic [TICK_W-1:0] now_tick;

  modport source (output valid, func, slot, timeout_ticks, user_tag, now_tick, input ready);
  modport sink   (input valid, func, slot, timeout_ticks, user_tag, now_tick, output ready);
endinterface

interface cbt_evt_if import cbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] fired_slot;
  logic [TAG_W-1:0]  fired_tag;
  logic              fired;
  logic              last;

  modport source (output valid, fired_slot, fired_tag, fired, last, input ready);
  modport sink   (input valid, fired_slot, fired_tag, fired, last, output ready);
endinterface

@@ design/callback_timer_bank.sv @@
// Top level of the callback timer bank: command decode, cell chain, hit collection.
//
//  channel | dir | transaction
//  --------+-----+--------------------------------------------------------------
//  cmd_i   | in  | func, slot, timeout_ticks, user_tag, now_tick
//  evt_o   | out | fired_slot, fired_tag, fired, last (one per expiry, or marker)
//
// Start, stop, restart and update are written straight into the addressed cell. A
// poll sends a token with now_tick down the chain of NUM_SLOTS cells, one cell per
// cycle unless the chain is held, then through the flush register; cmd_i.ready
// stays low meanwhile.
// Reset clears the running/enrolled flags, the chain tokens and the output valid;
// slot stores are undefined until started. The whole chain holds for every cycle in
// which a result has to enter the output register while evt_o keeps it full.
module callback_timer_bank import cbt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbt_cmd_if.sink   cmd_i,
  cbt_evt_if.source evt_o
);

  logic                           accept, adv, busy;
  logic                           done_q;
  cell_wr_t                       wr;
  logic      [NUM_SLOTS-1:0]      sel;
  logic      [NUM_SLOTS:0]        tok;
  logic      [NUM_SLOTS:0][TICK_W-1:0] now;
  cell_hit_t [NUM_SLOTS-1:0]      hits;
  logic                           hit_any;
  logic      [SLOT_W-1:0]         hit_slot;
  logic      [TAG_W-1:0]          hit_tag;

  // Busy while a poll token is in the chain or waiting to flush.
  assign busy        = (|tok[NUM_SLOTS:1]) || done_q;
  assign cmd_i.ready = !busy;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign wr.start   = accept && (cmd_i.func == FUNC_START);
  assign wr.stop    = accept && (cmd_i.func == FUNC_STOP);
  assign wr.restart = accept && (cmd_i.func == FUNC_RESTART);
  assign wr.update  = accept && (cmd_i.func == FUNC_UPDATE);
  assign wr.now     = cmd_i.now_tick;
  assign wr.timeout = cmd_i.timeout_ticks;
  assign wr.tag     = cmd_i.user_tag;

  // Token enters cell 0 on an accepted poll.
  assign tok[0] = accept && (cmd_i.func == FUNC_POLL);
  assign now[0] = cmd_i.now_tick;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    // slots beyond the command field's range are never addressed
    assign sel[g] = (int'(cmd_i.slot) == g);

    cbt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .sel_i  (sel[g]),
      .wr_i   (wr),
      .tok_i  (tok[g]),
      .now_i  (now[g]),
      .tok_o  (tok[g+1]),
      .now_o  (now[g+1]),
      .hit_o  (hits[g])
    );
  end

  // At most one cell holds the token, so the hits are one-hot: OR them together.
  always_comb begin
    hit_any  = 1'b0;
    hit_slot = '0;
    hit_tag  = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit_any  = hit_any | hits[i].hit;
      hit_slot = hit_slot | (hits[i].hit ? SLOT_W'(i) : '0);
      hit_tag  = hit_tag | hits[i].tag;
    end
  end

  // Token falls off the end of the chain: flush the held hit or emit the marker.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (adv) begin
      done_q <= tok[NUM_SLOTS];
    end
  end

  cbt_collect u_collect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hit_i  (hit_any),
    .slot_i (hit_slot),
    .tag_i  (hit_tag),
    .done_i (done_q),
    .adv_o  (adv),
    .evt_o  (evt_o)
  );

endmodule

@@ design/cbt_cell.sv @@
// One timer slot: slot state plus one stage of the poll token chain.
module cbt_cell import cbt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              sel_i,
  input  cell_wr_t          wr_i,
  input  logic              tok_i,
  input  logic [TICK_W-1:0] now_i,
  output logic              tok_o,
  output logic [TICK_W-1:0] now_o,
  output cell_hit_t         hit_o
);

  logic              tok_q;
  logic [TICK_W-1:0] now_q;
  logic              running_q, enrolled_q;
  logic [TICK_W-1:0] start_q, timeout_q;
  logic [TAG_W-1:0]  tag_q;
  logic [TICK_W-1:0] elapsed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q      <= 1'b0;
      running_q  <= 1'b0;
      enrolled_q <= 1'b0;
    end else begin
      if (adv_i) tok_q <= tok_i;
      if (sel_i) begin
        if (wr_i.start) begin
          running_q  <= 1'b1;
          enrolled_q <= 1'b1;
        end
        if (wr_i.stop)    running_q <= 1'b0;
        if (wr_i.restart) running_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) now_q <= now_i;
    if (sel_i) begin
      if (wr_i.start || wr_i.restart) start_q <= wr_i.now;
      if (wr_i.start || wr_i.update)  timeout_q <= wr_i.timeout;
      if (wr_i.start)                 tag_q <= wr_i.tag;
    end
  end

  // elapsed = now - start + 1, wrapping
  assign elapsed   = now_q - start_q + TICK_W'(1);
  assign hit_o.hit = tok_q && enrolled_q && running_q && (elapsed >= timeout_q);
  assign hit_o.tag = hit_o.hit ? tag_q : '0;
  assign tok_o     = tok_q;
  assign now_o     = now_q;

endmodule

@@ design/cbt_collect.sv @@
// Holds back one hit so the last flag is known, and drives the event output register.
module cbt_collect import cbt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hit_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [TAG_W-1:0]  tag_i,
  input  logic              done_i,
  output logic              adv_o,
  cbt_evt_if.source         evt_o
);

  logic              pv_q, pv_d;
  logic [SLOT_W-1:0] pslot_q;
  logic [TAG_W-1:0]  ptag_q;
  logic [CNT_W-1:0]  n_q, n_d;
  logic              ov_q, ov_d;
  logic [SLOT_W-1:0] oslot_d, oslot_q;
  logic [TAG_W-1:0]  otag_d, otag_q;
  logic              ofired_d, ofired_q, olast_d, olast_q;
  logic              hit_eff, out_free, load_out, load_pend;

  assign hit_eff  = hit_i && (n_q != CNT_W'(MAX_RESULTS));
  assign out_free = !ov_q || evt_o.ready;
  assign adv_o    = !((hit_eff && pv_q && !out_free) || (done_i && !out_free));

  always_comb begin
    pv_d      = pv_q;
    n_d       = n_q;
    load_out  = 1'b0;
    load_pend = 1'b0;
    oslot_d   = pslot_q;
    otag_d    = ptag_q;
    ofired_d  = 1'b1;
    olast_d   = 1'b0;
    if (adv_o) begin
      if (hit_eff) begin
        load_out  = pv_q;
        load_pend = 1'b1;
        pv_d      = 1'b1;
        n_d       = n_q + CNT_W'(1);
      end
      if (done_i) begin
        load_out = 1'b1;
        olast_d  = 1'b1;
        if (!pv_q) begin
          // empty poll marker
          oslot_d  = '0;
          otag_d   = '0;
          ofired_d = 1'b0;
        end
        pv_d = 1'b0;
        n_d  = '0;
      end
    end
    ov_d = load_out || (ov_q && !evt_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      n_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      pv_q <= pv_d;
      n_q  <= n_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_pend) begin
      pslot_q <= slot_i;
      ptag_q  <= tag_i;
    end
    if (load_out) begin
      oslot_q  <= oslot_d;
      otag_q   <= otag_d;
      ofired_q <= ofired_d;
      olast_q  <= olast_d;
    end
  end

  assign evt_o.valid      = ov_q;
  assign evt_o.fired_slot = oslot_q;
  assign evt_o.fired_tag  = otag_q;
  assign evt_o.fired      = ofired_q;
  assign evt_o.last       = olast_q;

endmodule
